/* design/pitd_pkg.sv */
// Shared constants and types for the packed index table decoder.
package pitd_pkg;

  // Parameter defaults
  localparam int unsigned MAX_INDEX_BITS_DEF = 12;
  localparam int unsigned PAYLOAD_WIDTH_DEF  = 16;

  // Fixed sizes
  localparam int unsigned BYTE_BITS    = 8;
  localparam int unsigned MAX_PER_BYTE = 8;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned WIDTH_REG_W  = 4;

  // Request function codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_BYTE  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_WIDTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_COUNT = 4'd1;

  localparam logic [WIDTH_REG_W-1:0] INDEX_WIDTH_RST = 4'd4;

  // Classified command passed from front to back
  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_START,
    CMD_BYTE
  } cmd_e;

  // Back-end sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

endpackage

/* design/pitd_if.sv */
// Request, result and configuration channel interfaces.
interface pitd_in_if
  import pitd_pkg::*;
#(
  parameter int unsigned IDX_W = MAX_INDEX_BITS_DEF,
  parameter int unsigned PAY_W = PAYLOAD_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic [IDX_W-1:0]     entry_index;
  logic [PAY_W-1:0]     entry_payload;
  logic [BYTE_BITS-1:0] stream_byte;

  modport source (output valid, func, entry_index, entry_payload, stream_byte, input ready);
  modport sink   (input valid, func, entry_index, entry_payload, stream_byte, output ready);
endinterface

interface pitd_out_if
  import pitd_pkg::*;
#(
  parameter int unsigned PAY_W = PAYLOAD_WIDTH_DEF
) ();
  logic             valid;
  logic             ready;
  logic [PAY_W-1:0] payload;
  logic             run_last;
  logic             stream_done;

  modport source (output valid, payload, run_last, stream_done, input ready);
  modport sink   (input valid, payload, run_last, stream_done, output ready);
endinterface

interface pitd_cfg_if
  import pitd_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/packed_index_table_decoder.sv */
// A data byte's first result passes the command queue, the holder, the table read register
//   and the result register. The back end takes one request at a time and yields at most 8
//   results per byte, none when no index completes, bounded by one table read per cycle
//   while the output does not stall; output stalls hold the back end.
// A 2-entry queue lets the front keep accepting, until it fills, while the back works or the output stalls.
// Reset clears the control state and configuration; the payload table is undefined
//   until written and has no clearing pass.
module packed_index_table_decoder
  import pitd_pkg::*;
#(
  parameter int unsigned MAX_INDEX_BITS = MAX_INDEX_BITS_DEF,
  parameter int unsigned PAYLOAD_WIDTH  = PAYLOAD_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pitd_cfg_if.sink   cfg_i,
  pitd_in_if.sink    in_i,
  pitd_out_if.source out_o
);

  localparam int unsigned WW    = $clog2(MAX_INDEX_BITS + 1);
  localparam int unsigned CMD_W = 2 + WW + MAX_INDEX_BITS + PAYLOAD_WIDTH + BYTE_BITS;

  logic               push;
  logic               full;
  logic [CMD_W-1:0]   front_cmd;
  logic               q_valid;
  logic               q_pop;
  logic [CMD_W-1:0]   q_cmd;
  logic [COUNT_W-1:0] value_count;

  pitd_front #(
    .MAX_INDEX_BITS (MAX_INDEX_BITS),
    .PAYLOAD_WIDTH  (PAYLOAD_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_i),
    .in_i          (in_i),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (front_cmd),
    .value_count_o (value_count)
  );

  pitd_fifo #(
    .DATA_W (CMD_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  pitd_back #(
    .MAX_INDEX_BITS (MAX_INDEX_BITS),
    .PAYLOAD_WIDTH  (PAYLOAD_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .q_pop_o       (q_pop),
    .value_count_i (value_count),
    .out_o         (out_o)
  );

endmodule

/* design/pitd_front.sv */
// Front end: configuration registers and request classification.
module pitd_front
  import pitd_pkg::*;
#(
  parameter int unsigned MAX_INDEX_BITS = MAX_INDEX_BITS_DEF,
  parameter int unsigned PAYLOAD_WIDTH  = PAYLOAD_WIDTH_DEF,
  localparam int unsigned WW    = $clog2(MAX_INDEX_BITS + 1),
  localparam int unsigned CMD_W = 2 + WW + MAX_INDEX_BITS + PAYLOAD_WIDTH + BYTE_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pitd_cfg_if.sink           cfg_i,
  pitd_in_if.sink            in_i,
  input  logic               full_i,
  output logic               push_o,
  output logic [CMD_W-1:0]   cmd_o,
  output logic [COUNT_W-1:0] value_count_o
);

  typedef struct packed {
    cmd_e                      op;
    logic [WW-1:0]             width;
    logic [MAX_INDEX_BITS-1:0] addr;
    logic [PAYLOAD_WIDTH-1:0]  data;
    logic [BYTE_BITS-1:0]      sbyte;
  } cmd_t;

  logic [WIDTH_REG_W-1:0] index_width_q;
  logic [COUNT_W-1:0]     value_count_q;
  logic [WW-1:0]          eff_width;
  cmd_t                   cmd;
  logic                   known;

  // Configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_width_q <= INDEX_WIDTH_RST;
      value_count_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_INDEX_WIDTH) begin
        index_width_q <= cfg_i.data[WIDTH_REG_W-1:0];
      end else if (cfg_i.index == CFG_VALUE_COUNT) begin
        value_count_q <= cfg_i.data[COUNT_W-1:0];
      end
    end
  end

  assign value_count_o = value_count_q;

  // Clamp width into 1..MAX_INDEX_BITS
  always_comb begin
    if (index_width_q == '0) begin
      eff_width = WW'(1);
    end else if (int'(index_width_q) > MAX_INDEX_BITS) begin
      eff_width = WW'(MAX_INDEX_BITS);
    end else begin
      eff_width = WW'(index_width_q);
    end
  end

  // Classify request; unused function code is dropped here
  always_comb begin
    cmd.op    = CMD_WRITE;
    cmd.width = eff_width;
    cmd.addr  = in_i.entry_index;
    cmd.data  = in_i.entry_payload;
    cmd.sbyte = in_i.stream_byte;
    known     = 1'b1;
    unique case (in_i.func)
      FUNC_WRITE: cmd.op = CMD_WRITE;
      FUNC_START: cmd.op = CMD_START;
      FUNC_BYTE:  cmd.op = CMD_BYTE;
      default:    known  = 1'b0;
    endcase
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i && known;
  assign cmd_o      = cmd;

endmodule

/* design/pitd_fifo.sv */
// Short command queue between front and back.
module pitd_fifo
  import pitd_pkg::*;
#(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = QUEUE_DEPTH,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] entries_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;
  logic              do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/pitd_back.sv */
// Back end: bit holder, index extraction, payload table and result register.
module pitd_back
  import pitd_pkg::*;
#(
  parameter int unsigned MAX_INDEX_BITS = MAX_INDEX_BITS_DEF,
  parameter int unsigned PAYLOAD_WIDTH  = PAYLOAD_WIDTH_DEF,
  localparam int unsigned WW     = $clog2(MAX_INDEX_BITS + 1),
  localparam int unsigned CMD_W  = 2 + WW + MAX_INDEX_BITS + PAYLOAD_WIDTH + BYTE_BITS,
  localparam int unsigned HOLD_W = MAX_INDEX_BITS + BYTE_BITS,
  localparam int unsigned HB     = $clog2(HOLD_W),
  localparam int unsigned DEPTH  = 1 << MAX_INDEX_BITS,
  localparam int unsigned CNT_W  = $clog2(MAX_PER_BYTE)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  logic [CMD_W-1:0]   q_cmd_i,
  output logic               q_pop_o,
  input  logic [COUNT_W-1:0] value_count_i,
  pitd_out_if.source         out_o
);

  typedef struct packed {
    cmd_e                      op;
    logic [WW-1:0]             width;
    logic [MAX_INDEX_BITS-1:0] addr;
    logic [PAYLOAD_WIDTH-1:0]  data;
    logic [BYTE_BITS-1:0]      sbyte;
  } cmd_t;

  cmd_t                      cmd;
  state_e                    state_q, state_d;
  logic [HOLD_W-1:0]         holder_q, holder_d;
  logic [HB-1:0]             held_q, held_d;
  logic [COUNT_W-1:0]        left_q, left_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [WW-1:0]             w_q, w_d;
  logic [HB-1:0]             held_nx;
  logic [MAX_INDEX_BITS-1:0] rd_idx;
  logic                      avail;
  logic                      issue;
  logic                      issue_ok;
  logic                      tbl_we;
  logic                      res_last;
  logic                      res_done;
  logic                      out_adv;

  logic [PAYLOAD_WIDTH-1:0]  table_q [DEPTH];
  logic [PAYLOAD_WIDTH-1:0]  rd_data_q;
  logic                      rd_valid_q;
  logic                      rd_last_q;
  logic                      rd_done_q;
  logic                      out_valid_q;
  logic [PAYLOAD_WIDTH-1:0]  out_payload_q;
  logic                      out_last_q;
  logic                      out_done_q;

  assign cmd = cmd_t'(q_cmd_i);

  // Next index from the bottom of the holder
  always_comb begin
    for (int i = 0; i < MAX_INDEX_BITS; i++) begin
      rd_idx[i] = holder_q[i] && (i < int'(w_q));
    end
  end

  assign held_nx  = held_q - HB'(w_q);
  assign avail    = (held_q >= HB'(w_q)) && (left_q != '0);
  assign out_adv  = !out_valid_q || out_o.ready;
  assign issue_ok = !rd_valid_q || out_adv;

  // Sequencer outputs and datapath updates
  always_comb begin
    q_pop_o  = 1'b0;
    tbl_we   = 1'b0;
    issue    = 1'b0;
    res_last = 1'b0;
    res_done = 1'b0;
    holder_d = holder_q;
    held_d   = held_q;
    left_d   = left_q;
    cnt_d    = cnt_q;
    w_d      = w_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (cmd.op)
            CMD_WRITE: tbl_we = 1'b1;
            CMD_START: begin
              left_d   = value_count_i;
              holder_d = '0;
              held_d   = '0;
            end
            CMD_BYTE: begin
              if (left_q == '0) begin
                holder_d = '0;
                held_d   = '0;
              end else begin
                holder_d = holder_q | (HOLD_W'(cmd.sbyte) << held_q);
                held_d   = held_q + HB'(BYTE_BITS);
                w_d      = cmd.width;
                cnt_d    = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (avail && issue_ok) begin
          issue    = 1'b1;
          holder_d = holder_q >> w_q;
          held_d   = held_nx;
          left_d   = left_q - COUNT_W'(1);
          cnt_d    = cnt_q + CNT_W'(1);
          res_done = (left_q == COUNT_W'(1));
          res_last = (cnt_q == CNT_W'(MAX_PER_BYTE - 1)) || (held_nx < HB'(w_q)) || res_done;
          if (res_done) begin
            holder_d = '0;
            held_d   = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && (cmd.op == CMD_BYTE) && (left_q != '0)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!avail || (issue && res_last)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      holder_q    <= '0;
      held_q      <= '0;
      left_q      <= '0;
      cnt_q       <= '0;
      w_q         <= WW'(1);
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      holder_q <= holder_d;
      held_q   <= held_d;
      left_q   <= left_d;
      cnt_q    <= cnt_d;
      w_q      <= w_d;
      if (issue) begin
        rd_valid_q <= 1'b1;
      end else if (out_adv) begin
        rd_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= rd_valid_q;
      end
    end
  end

  // Payload table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      table_q[cmd.addr] <= cmd.data;
    end
    if (issue) begin
      rd_data_q <= table_q[rd_idx];
      rd_last_q <= res_last;
      rd_done_q <= res_done;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_adv && rd_valid_q) begin
      out_payload_q <= rd_data_q;
      out_last_q    <= rd_last_q;
      out_done_q    <= rd_done_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.payload     = out_payload_q;
  assign out_o.run_last    = out_last_q;
  assign out_o.stream_done = out_done_q;

  // No bits held above the fill level
  a_holder_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (holder_q >> held_q) == '0)
    else $error("holder has bits above fill level");

  // A finished stream leaves nothing held
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && left_q == '0) |-> (held_q == '0))
    else $error("bits held after stream end");

  // Last value of a stream also closes the byte's run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && res_done) |-> res_last)
    else $error("stream_done without run_last");

  // A read only enters a free or draining read stage
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q && out_valid_q && !out_o.ready) |-> !issue)
    else $error("table read overruns stalled result");

endmodule
